/* design/miller_index_plane_basis_defines.svh */
// Assertion macros used by the plane basis datapath.
`ifndef MILLER_INDEX_PLANE_BASIS_DEFINES_SVH
`define MILLER_INDEX_PLANE_BASIS_DEFINES_SVH

// same-cycle implication
`define MIPB_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MIPB_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mipb_pkg.sv */
// Types, constants and helper functions for the Miller index plane basis block.
package mipb_pkg;

    localparam int INDEX_BITS = 8;
    localparam int OUT_BITS   = 16;
    localparam int MAG_BITS   = INDEX_BITS;
    localparam int CNT_BITS   = $clog2(MAG_BITS + 1);

    typedef struct packed {
        logic signed [INDEX_BITS-1:0] index_h;
        logic signed [INDEX_BITS-1:0] index_k;
        logic signed [INDEX_BITS-1:0] index_l;
    } index_word_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] first_x;
        logic signed [OUT_BITS-1:0] first_y;
        logic signed [OUT_BITS-1:0] first_z;
        logic signed [OUT_BITS-1:0] second_x;
        logic signed [OUT_BITS-1:0] second_y;
        logic signed [OUT_BITS-1:0] second_z;
    } basis_word_t;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_ONE,
        CLS_TWO
    } zero_class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_GCD,
        ST_DIV_U,
        ST_DIV_V,
        ST_FINISH
    } state_t;

    localparam logic JOB_FIRST  = 1'b0;
    localparam logic JOB_SECOND = 1'b1;
    localparam logic WHICH_U    = 1'b0;
    localparam logic WHICH_V    = 1'b1;

    localparam logic [1:0] SLOT_FIRST_U  = {JOB_FIRST, WHICH_U};
    localparam logic [1:0] SLOT_FIRST_V  = {JOB_FIRST, WHICH_V};
    localparam logic [1:0] SLOT_SECOND_U = {JOB_SECOND, WHICH_U};
    localparam logic [1:0] SLOT_SECOND_V = {JOB_SECOND, WHICH_V};

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       gcd_load;
        logic       gcd_job;
        logic       gcd_step;
        logic       g_latch;
        logic       div_load;
        logic [1:0] div_slot;
        logic       div_step;
        logic       store;
        logic       out_load;
    } mipb_cmd_t;

    typedef struct packed {
        zero_class_t zclass;
        logic        gcd_done;
        logic        div_done;
        logic        out_free;
    } mipb_stat_t;

    function automatic logic [MAG_BITS-1:0] magnitude(input logic [INDEX_BITS-1:0] v);
        return v[INDEX_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [OUT_BITS-1:0] apply_sign(input logic [MAG_BITS-1:0] q,
                                                       input logic neg);
        logic [31:0] e;
        e = 32'(q);
        if (neg)
        begin
            e = 32'd0 - e;
        end
        return e[OUT_BITS-1:0];
    endfunction

endpackage

/* design/mipb_datapath.sv */
// Datapath: index capture, zero classification, shared gcd/divide unit, result register.
`include "miller_index_plane_basis_defines.svh"

module mipb_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mipb_pkg::index_word_t index_word,
    input  mipb_pkg::mipb_cmd_t  cmd,
    output mipb_pkg::mipb_stat_t stat,
    output mipb_pkg::basis_word_t basis_word,
    output logic                 basis_valid,
    input  logic                 basis_stall
);
    import mipb_pkg::*;

    index_word_t         idx_reg;
    logic [MAG_BITS-1:0] x_reg, x_next;
    logic [MAG_BITS-1:0] y_reg, y_next;
    logic [MAG_BITS-1:0] g_reg, g_next;
    logic [CNT_BITS-1:0] shift_reg, shift_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [1:0]          dslot_reg, dslot_next;
    logic [MAG_BITS-1:0] q_reg [4];
    basis_word_t         basis_word_reg;
    logic                basis_valid_reg, basis_valid_next;

    logic                  zh, zk, zl;
    logic [1:0]            zeros;
    zero_class_t           zclass;
    logic [1:0]            perm0, perm1, perm2;
    logic [INDEX_BITS-1:0] p1, p2;
    logic [MAG_BITS-1:0]   mh, mk, ml, mp1, mp2;
    logic [MAG_BITS-1:0]   gu_second, gv_second;
    logic [MAG_BITS-1:0]   dividend;
    logic [MAG_BITS:0]     trial;
    logic [MAG_BITS:0]     diff;
    logic                  n0, n1, n2, n3;
    logic [OUT_BITS-1:0]   v0, v1, v2, v3;
    logic [OUT_BITS-1:0]   first_v [3];
    logic [OUT_BITS-1:0]   second_v [3];
    logic                  out_free;

    function automatic logic [INDEX_BITS-1:0] pick(input logic [1:0] sel,
                                                   input logic [INDEX_BITS-1:0] h,
                                                   input logic [INDEX_BITS-1:0] k,
                                                   input logic [INDEX_BITS-1:0] l);
        logic [INDEX_BITS-1:0] r;
        case (sel)
            AXIS_X:  r = h;
            AXIS_Y:  r = k;
            default: r = l;
        endcase
        return r;
    endfunction

    // classification and permutation
    always_comb
    begin
        zh    = (idx_reg.index_h == '0);
        zk    = (idx_reg.index_k == '0);
        zl    = (idx_reg.index_l == '0);
        zeros = {1'b0, zh} + {1'b0, zk} + {1'b0, zl};
        case (zeros)
            2'd0:    zclass = CLS_NONE;
            2'd1:    zclass = CLS_ONE;
            default: zclass = CLS_TWO;
        endcase
        perm0 = AXIS_X;
        perm1 = AXIS_Y;
        perm2 = AXIS_Z;
        if (zh)
        begin
            if (!zk && zl)
            begin
                perm1 = AXIS_Z;
                perm2 = AXIS_Y;
            end
        end
        else if (zk)
        begin
            perm0 = AXIS_Y;
            if (zl)
            begin
                perm1 = AXIS_Z;
                perm2 = AXIS_X;
            end
            else
            begin
                perm1 = AXIS_X;
            end
        end
        else if (zl)
        begin
            perm0 = AXIS_Z;
            perm2 = AXIS_X;
        end
        p1  = pick(perm1, idx_reg.index_h, idx_reg.index_k, idx_reg.index_l);
        p2  = pick(perm2, idx_reg.index_h, idx_reg.index_k, idx_reg.index_l);
        mh  = magnitude(idx_reg.index_h);
        mk  = magnitude(idx_reg.index_k);
        ml  = magnitude(idx_reg.index_l);
        mp1 = magnitude(p1);
        mp2 = magnitude(p2);
        gu_second = (zclass == CLS_NONE) ? ml : mp2;
        gv_second = (zclass == CLS_NONE) ? mk : mp1;
    end

    always_comb
    begin
        case (cmd.div_slot)
            SLOT_FIRST_U:  dividend = ml;
            SLOT_FIRST_V:  dividend = mh;
            SLOT_SECOND_U: dividend = gu_second;
            default:       dividend = gv_second;
        endcase
    end

    // shared subtract-shift unit: binary gcd, then restoring division
    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        g_next     = g_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        dslot_next = dslot_reg;
        trial      = {x_reg, y_reg[MAG_BITS-1]};
        diff       = trial - {1'b0, g_reg};
        if (cmd.gcd_load)
        begin
            x_next     = (cmd.gcd_job == JOB_FIRST) ? ml : gu_second;
            y_next     = (cmd.gcd_job == JOB_FIRST) ? mh : gv_second;
            shift_next = '0;
        end
        else if (cmd.gcd_step)
        begin
            if (!x_reg[0] && !y_reg[0])
            begin
                x_next     = x_reg >> 1;
                y_next     = y_reg >> 1;
                shift_next = shift_reg + 1'b1;
            end
            else if (!x_reg[0])
            begin
                x_next = x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_next = y_reg >> 1;
            end
            else if (x_reg > y_reg)
            begin
                x_next = (x_reg - y_reg) >> 1;
            end
            else
            begin
                y_next = (y_reg - x_reg) >> 1;
            end
        end
        if (cmd.g_latch)
        begin
            g_next = x_reg << shift_reg;
        end
        if (cmd.div_load)
        begin
            x_next     = '0;
            y_next     = dividend;
            cnt_next   = '0;
            dslot_next = cmd.div_slot;
        end
        else if (cmd.div_step)
        begin
            if (trial >= {1'b0, g_reg})
            begin
                x_next = diff[MAG_BITS-1:0];
                y_next = {y_reg[MAG_BITS-2:0], 1'b1};
            end
            else
            begin
                x_next = trial[MAG_BITS-1:0];
                y_next = {y_reg[MAG_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // result assembly
    always_comb
    begin
        n0 = idx_reg.index_k[INDEX_BITS-1] ^ idx_reg.index_l[INDEX_BITS-1];
        n1 = ~(idx_reg.index_k[INDEX_BITS-1] ^ idx_reg.index_h[INDEX_BITS-1]);
        n2 = (zclass == CLS_NONE)
           ? (idx_reg.index_h[INDEX_BITS-1] ^ idx_reg.index_l[INDEX_BITS-1])
           : p2[INDEX_BITS-1];
        n3 = (zclass == CLS_NONE)
           ? ~(idx_reg.index_h[INDEX_BITS-1] ^ idx_reg.index_k[INDEX_BITS-1])
           : ~p1[INDEX_BITS-1];
        v0 = apply_sign(q_reg[SLOT_FIRST_U], n0);
        v1 = apply_sign(q_reg[SLOT_FIRST_V], n1);
        v2 = apply_sign(q_reg[SLOT_SECOND_U], n2);
        v3 = apply_sign(q_reg[SLOT_SECOND_V], n3);
        for (int i = 0; i < 3; i++)
        begin
            first_v[i]  = '0;
            second_v[i] = '0;
            case (zclass)
                CLS_NONE:
                begin
                    if (2'(i) == AXIS_X)
                    begin
                        first_v[i] = v0;
                    end
                    if (2'(i) == AXIS_Z)
                    begin
                        first_v[i]  = v1;
                        second_v[i] = v3;
                    end
                    if (2'(i) == AXIS_Y)
                    begin
                        second_v[i] = v2;
                    end
                end
                CLS_ONE:
                begin
                    if (2'(i) == perm0)
                    begin
                        first_v[i] = OUT_BITS'(1);
                    end
                    if (2'(i) == perm1)
                    begin
                        second_v[i] = v2;
                    end
                    if (2'(i) == perm2)
                    begin
                        second_v[i] = v3;
                    end
                end
                default:
                begin
                    if (2'(i) == perm0)
                    begin
                        first_v[i] = OUT_BITS'(1);
                    end
                    if (2'(i) == perm1)
                    begin
                        second_v[i] = OUT_BITS'(1);
                    end
                end
            endcase
        end
    end

    assign out_free         = !basis_valid_reg || !basis_stall;
    assign basis_valid_next = cmd.out_load ? 1'b1 : (basis_valid_reg && basis_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            basis_valid_reg <= 1'b0;
        end
        else
        begin
            basis_valid_reg <= basis_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg <= index_word;
        end
        x_reg     <= x_next;
        y_reg     <= y_next;
        g_reg     <= g_next;
        shift_reg <= shift_next;
        cnt_reg   <= cnt_next;
        dslot_reg <= dslot_next;
        if (cmd.store)
        begin
            q_reg[dslot_reg] <= y_reg;
        end
        if (cmd.out_load)
        begin
            basis_word_reg.first_x  <= first_v[AXIS_X];
            basis_word_reg.first_y  <= first_v[AXIS_Y];
            basis_word_reg.first_z  <= first_v[AXIS_Z];
            basis_word_reg.second_x <= second_v[AXIS_X];
            basis_word_reg.second_y <= second_v[AXIS_Y];
            basis_word_reg.second_z <= second_v[AXIS_Z];
        end
    end

    assign stat.zclass   = zclass;
    assign stat.gcd_done = (x_reg == y_reg);
    assign stat.div_done = (cnt_reg == CNT_BITS'(MAG_BITS));
    assign stat.out_free = out_free;
    assign basis_word    = basis_word_reg;
    assign basis_valid   = basis_valid_reg;

    `MIPB_ASSERT_NOW(a_gcd_live, clk, rst_n, cmd.gcd_step, x_reg != y_reg, "gcd stepped after convergence")
    `MIPB_ASSERT_NEXT(a_g_nonzero, clk, rst_n, cmd.g_latch, g_reg != '0, "zero gcd latched")
    `MIPB_ASSERT_NOW(a_exact_div, clk, rst_n, cmd.store, x_reg == '0, "quotient stored with remainder")
    `MIPB_ASSERT_NOW(a_div_bound, clk, rst_n, cmd.div_step, cnt_reg != CNT_BITS'(MAG_BITS), "divide overrun")
    `MIPB_ASSERT_NOW(a_out_free, clk, rst_n, cmd.out_load, out_free, "result register overwritten")

endmodule

/* design/mipb_controller.sv */
// Controller: sequences capture, gcd and divide passes, and result hand-off.
module mipb_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 index_valid,
    output logic                 index_stall,
    input  mipb_pkg::mipb_stat_t stat,
    output mipb_pkg::mipb_cmd_t  cmd
);
    import mipb_pkg::*;

    state_t state_reg, state_next;
    logic   job_reg, job_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg   <= JOB_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (index_valid)
                begin
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                case (stat.zclass)
                    CLS_NONE:
                    begin
                        job_next   = JOB_FIRST;
                        state_next = ST_GCD;
                    end
                    CLS_ONE:
                    begin
                        job_next   = JOB_SECOND;
                        state_next = ST_GCD;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_GCD:
            begin
                if (stat.gcd_done)
                begin
                    state_next = ST_DIV_U;
                end
            end
            ST_DIV_U:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_DIV_V;
                end
            end
            ST_DIV_V:
            begin
                if (stat.div_done)
                begin
                    if (job_reg == JOB_FIRST)
                    begin
                        job_next   = JOB_SECOND;
                        state_next = ST_GCD;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        index_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                index_stall = 1'b0;
                cmd.capture = index_valid;
            end
            ST_CLASSIFY:
            begin
                case (stat.zclass)
                    CLS_NONE:
                    begin
                        cmd.gcd_load = 1'b1;
                        cmd.gcd_job  = JOB_FIRST;
                    end
                    CLS_ONE:
                    begin
                        cmd.gcd_load = 1'b1;
                        cmd.gcd_job  = JOB_SECOND;
                    end
                    default:
                    begin
                        cmd.gcd_load = 1'b0;
                    end
                endcase
            end
            ST_GCD:
            begin
                if (stat.gcd_done)
                begin
                    cmd.g_latch  = 1'b1;
                    cmd.div_load = 1'b1;
                    cmd.div_slot = {job_reg, WHICH_U};
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV_U:
            begin
                if (stat.div_done)
                begin
                    cmd.store    = 1'b1;
                    cmd.div_load = 1'b1;
                    cmd.div_slot = {job_reg, WHICH_V};
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_DIV_V:
            begin
                if (stat.div_done)
                begin
                    cmd.store = 1'b1;
                    if (job_reg == JOB_FIRST)
                    begin
                        cmd.gcd_load = 1'b1;
                        cmd.gcd_job  = JOB_SECOND;
                    end
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_FINISH:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                index_stall = 1'b1;
            end
        endcase
    end

endmodule

/* design/miller_index_plane_basis.sv */
// Top level: Miller index to two gcd-reduced in-plane lattice vectors.
// One index word in, one basis word out. Words are handled one at a time: a word is taken
// in the idle state, then the shared subtract-shift unit runs a binary gcd, latches it,
// and runs two restoring divisions, once for each vector that needs reducing. An index
// with no zero component reduces both vectors; one zero reduces one vector; two or three
// zeros reduce none. The result sits in an output register, so the next index is taken
// while it waits.
module miller_index_plane_basis (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  index_valid,
    output logic                  index_stall,
    input  mipb_pkg::index_word_t index_word,
    output logic                  basis_valid,
    input  logic                  basis_stall,
    output mipb_pkg::basis_word_t basis_word
);
    import mipb_pkg::*;

    mipb_cmd_t  cmd;
    mipb_stat_t stat;

    mipb_controller u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .index_valid (index_valid),
        .index_stall (index_stall),
        .stat        (stat),
        .cmd         (cmd)
    );

    mipb_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .index_word  (index_word),
        .cmd         (cmd),
        .stat        (stat),
        .basis_word  (basis_word),
        .basis_valid (basis_valid),
        .basis_stall (basis_stall)
    );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for miller_index_plane_basis: directed and random index words checked against a predictor.
module tb_top;
    import mipb_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 100;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        index_valid = 1'b0;
    logic        index_stall;
    index_word_t index_word  = '0;
    logic        basis_valid;
    logic        basis_stall = 1'b0;
    basis_word_t basis_word;

    basis_word_t basis_expected[$];
    string       field_names[6] = '{"first_x", "first_y", "first_z",
                                    "second_x", "second_y", "second_z"};
    int          errors        = 0;
    int          words_sent    = 0;
    int          words_checked = 0;
    int          zero_tally[4] = '{0, 0, 0, 0};
    int          cycles        = 0;
    int          stall_left    = 0;
    bit          idle_on       = 1'b1;

    always #4 clk = ~clk;

    miller_index_plane_basis dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .index_valid (index_valid),
        .index_stall (index_stall),
        .index_word  (index_word),
        .basis_valid (basis_valid),
        .basis_stall (basis_stall),
        .basis_word  (basis_word)
    );

    function automatic longint gcd_mag(longint x, longint y);
        longint a;
        longint b;
        longint t;
        a = (x < 0) ? -x : x;
        b = (y < 0) ? -y : y;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic basis_word_t plane_basis(index_word_t w);
        longint      c[3];
        longint      p[3];
        longint      vec[2][3];
        logic [15:0] lanes[6];
        longint      d;
        int          ord[3];
        int          i;
        int          j;
        int          t;
        int          v;
        basis_word_t r;
        c[0] = longint'($signed(w.index_h));
        c[1] = longint'($signed(w.index_k));
        c[2] = longint'($signed(w.index_l));
        for (i = 0; i < 3; i++)
        begin
            ord[i] = i;
        end
        // first zero to slot 0, a second zero among the rest to slot 1
        j = 0;
        while (j < 3 && c[j] != 0)
        begin
            j++;
        end
        if (j < 3)
        begin
            t = ord[0]; ord[0] = ord[j]; ord[j] = t;
            j = 1;
            while (j < 3 && c[ord[j]] != 0)
            begin
                j++;
            end
            if (j < 3)
            begin
                t = ord[1]; ord[1] = ord[j]; ord[j] = t;
            end
        end
        for (i = 0; i < 3; i++)
        begin
            p[i] = c[ord[i]];
        end
        if (p[0] == 0 && p[1] == 0)
        begin
            vec[0][0] = 1; vec[0][1] = 0; vec[0][2] = 0;
            vec[1][0] = 0; vec[1][1] = 1; vec[1][2] = 0;
        end
        else if (p[0] == 0)
        begin
            vec[0][0] = 1; vec[0][1] = 0;    vec[0][2] = 0;
            vec[1][0] = 0; vec[1][1] = p[2]; vec[1][2] = -p[1];
        end
        else
        begin
            vec[0][0] = p[1] * p[2]; vec[0][1] = 0;           vec[0][2] = -(p[0] * p[1]);
            vec[1][0] = 0;           vec[1][1] = p[0] * p[2]; vec[1][2] = -(p[0] * p[1]);
        end
        for (v = 0; v < 2; v++)
        begin
            d = gcd_mag(gcd_mag(vec[v][0], vec[v][1]), vec[v][2]);
            if (d == 0)
            begin
                d = 1;
            end
            for (i = 0; i < 3; i++)
            begin
                vec[v][i] = vec[v][i] / d;
            end
        end
        for (i = 0; i < 3; i++)
        begin
            lanes[ord[i]]     = 16'(vec[0][i]);
            lanes[3 + ord[i]] = 16'(vec[1][i]);
        end
        r = {lanes[0], lanes[1], lanes[2], lanes[3], lanes[4], lanes[5]};
        return r;
    endfunction

    function automatic index_word_t idx(int h, int k, int l);
        index_word_t r;
        r = {8'(h), 8'(k), 8'(l)};
        return r;
    endfunction

    // mostly no-zero indexes over the full range, plus zero patterns and small values
    function automatic index_word_t random_index();
        logic [7:0] comp[3];
        int         mode;
        int         zpos;
        int         i;
        index_word_t r;
        mode = $urandom_range(0, 9);
        for (i = 0; i < 3; i++)
        begin
            if (mode == 9)
            begin
                comp[i] = 8'($urandom_range(0, 12)) - 8'd6;
            end
            else
            begin
                do
                begin
                    comp[i] = 8'($urandom_range(0, 255));
                end
                while (comp[i] == 8'd0);
            end
        end
        zpos = $urandom_range(0, 2);
        if (mode == 6 || mode == 7)
        begin
            comp[zpos] = 8'd0;
        end
        else if (mode == 8)
        begin
            for (i = 0; i < 3; i++)
            begin
                if (i != zpos)
                begin
                    comp[i] = 8'd0;
                end
            end
        end
        r = {comp[0], comp[1], comp[2]};
        return r;
    endfunction

    task automatic send_index(input index_word_t w);
        int gap;
        int zeros;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            index_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        index_valid <= 1'b1;
        index_word  <= w;
        @(posedge clk);
        while (index_stall)
        begin
            @(posedge clk);
        end
        basis_expected = {basis_expected, plane_basis(w)};
        words_sent++;
        zeros = int'(w.index_h == 0) + int'(w.index_k == 0) + int'(w.index_l == 0);
        zero_tally[zeros]++;
    endtask

    task automatic test_zero_patterns();
        send_index(idx(0, 0, 0));
        send_index(idx(5, 0, 0));
        send_index(idx(0, -7, 0));
        send_index(idx(0, 0, 127));
        send_index(idx(0, 6, -4));
        send_index(idx(-128, 0, 12));
        send_index(idx(9, -3, 0));
        send_index(idx(0, -128, -128));
    endtask

    task automatic test_extremes();
        send_index(idx(-128, -128, -128));
        send_index(idx(127, 127, 127));
        send_index(idx(-128, 127, -1));
        send_index(idx(1, 1, 1));
        send_index(idx(-1, -1, -1));
        send_index(idx(127, -128, 1));
        send_index(idx(-128, -128, 127));
        send_index(idx(2, 4, 6));
        send_index(idx(6, 10, 15));
        send_index(idx(-85, 51, -119));
    endtask

    task automatic test_random_idle();
        int n;
        for (n = 0; n < 600; n++)
        begin
            send_index(random_index());
        end
    endtask

    // back to back, no idling on either side
    task automatic test_random_steady();
        int n;
        idle_on = 1'b0;
        for (n = 0; n < 200; n++)
        begin
            send_index(random_index());
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            basis_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            basis_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 4);
        end
        else
        begin
            basis_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_basis
        basis_word_t want;
        logic [15:0] e;
        logic [15:0] a;
        int          f;
        if (rst_n && basis_valid && !basis_stall)
        begin
            if (basis_expected.size() == 0)
            begin
                $error("unexpected basis word %h", basis_word);
                errors++;
            end
            else
            begin
                want = basis_expected.pop_front();
                words_checked++;
                for (f = 0; f < 6; f++)
                begin
                    e = want[95 - 16 * f -: 16];
                    a = basis_word[95 - 16 * f -: 16];
                    if (e !== a)
                    begin
                        $error("%s: expected %0d, got %0d", field_names[f],
                               $signed(e), $signed(a));
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("tb_top: timeout with %0d words outstanding", basis_expected.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_patterns();
        test_extremes();
        test_random_idle();
        test_random_steady();
        index_valid <= 1'b0;
        while (basis_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("tb_top: %0d index words sent, %0d basis words checked in %0d cycles",
                 words_sent, words_checked, cycles);
        $display("tb_top: indexes with no zero %0d, one zero %0d, two or three zeros %0d",
                 zero_tally[0], zero_tally[1], zero_tally[2] + zero_tally[3]);
        if (errors == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

/* miller_index_plane_basis.f */
+incdir+design
design/mipb_pkg.sv
design/mipb_datapath.sv
design/mipb_controller.sv
design/miller_index_plane_basis.sv
test/tb_top.sv
